// ===== src/palindrome_radius_engine_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the palindrome radius engine
// Each macro expects a clock named clock and a synchronous reset named reset.
// ---------------------------------------------------------------------------
`ifndef PALINDROME_RADIUS_ENGINE_UNIT_MACROS_SVH
`define PALINDROME_RADIUS_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication
`define PRE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define PRE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/pre_pkg.sv =====
// ---------------------------------------------------------------------------
// pre_pkg
// Shared types, field widths and codes of the palindrome radius engine.
// ---------------------------------------------------------------------------
package pre_pkg;

   localparam int MAX_LEN_DEF = 1024;

   localparam int CHAR_W   = 8;
   localparam int IDX_W    = 10;
   localparam int RANGE_W  = 11;
   localparam int LEN_W    = 11;
   localparam int START_W  = 10;
   localparam int RAD_W    = 10;
   localparam int OLEN_W   = 10;
   localparam int ELEN_W   = 11;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 64;

   // tuser codes
   localparam logic ACT_APPEND   = 1'b0;
   localparam logic ACT_QUERY    = 1'b1;
   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_QUERY   = 1'b1;

   // Radius memory read source
   typedef enum logic [1:0] {
      RD_MIRROR,
      RD_ODD,
      RD_EVEN,
      RD_RANGE
   } rd_sel_type;

   // Request tdata, lowest field last
   typedef struct packed {
      logic [RANGE_W-1:0] range_end;
      logic [RANGE_W-1:0] range_start;
      logic [IDX_W-1:0]   index;
      logic [CHAR_W-1:0]  char_in;
   } req_data_type;

   // Response tdata, lowest field last
   typedef struct packed {
      logic               error;
      logic               is_pal;
      logic [ELEN_W-1:0]  even_len;
      logic [RAD_W-1:0]   even_radius;
      logic [OLEN_W-1:0]  odd_len;
      logic [RAD_W-1:0]   odd_radius;
      logic [START_W-1:0] longest_start;
      logic [LEN_W-1:0]   longest_len;
   } rsp_data_type;

   // Controller to datapath
   typedef struct packed {
      logic       append;
      logic       latch_q;
      logic       build_init;
      logic       r_inc;
      logic       char_rd;
      logic       wr_center;
      logic       rad_rd;
      rd_sel_type rd_sel;
      logic       mir_wr;
      logic       advance;
      logic       cap_odd;
      logic       cap_even;
      logic       load_sum;
      logic       load_qry;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_free;
      logic bounds_ok;
      logic sep_pos;
      logic chars_eq;
      logic mir_ok;
      logic mir_more;
      logic done_next;
   } sts_type;

endpackage

// ===== src/pre_ctrl.sv =====
// ---------------------------------------------------------------------------
// pre_ctrl
// Sequencer for appends, the Manacher build and radius queries.
// ---------------------------------------------------------------------------
module pre_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_action,
   input  logic             req_last,
   output logic             req_tready,
   input  pre_pkg::sts_type sts,
   output pre_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXT,
      S_EXT_CMP,
      S_MIR_RD,
      S_MIR_CHK,
      S_SUM,
      S_Q_ODD,
      S_Q_EVEN,
      S_Q_RANGE,
      S_Q_RESP
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_action == pre_pkg::ACT_APPEND) begin
                  cmd.append = 1'b1;
                  if (req_last) begin
                     cmd.build_init = 1'b1;
                     state_in       = S_EXT;
                  end
               end else begin
                  cmd.latch_q = 1'b1;
                  state_in    = S_Q_ODD;
               end
            end
         end
         S_EXT: begin
            if (!sts.bounds_ok) begin
               cmd.wr_center = 1'b1;
               state_in      = S_MIR_RD;
            end else if (sts.sep_pos) begin
               cmd.r_inc = 1'b1;
            end else begin
               cmd.char_rd = 1'b1;
               state_in    = S_EXT_CMP;
            end
         end
         S_EXT_CMP: begin
            if (sts.chars_eq) begin
               cmd.r_inc = 1'b1;
               state_in  = S_EXT;
            end else begin
               cmd.wr_center = 1'b1;
               state_in      = S_MIR_RD;
            end
         end
         S_MIR_RD: begin
            if (sts.mir_ok) begin
               cmd.rad_rd = 1'b1;
               cmd.rd_sel = pre_pkg::RD_MIRROR;
               state_in   = S_MIR_CHK;
            end else begin
               cmd.advance = 1'b1;
               state_in    = sts.done_next ? S_SUM : S_EXT;
            end
         end
         S_MIR_CHK: begin
            if (sts.mir_more) begin
               cmd.mir_wr = 1'b1;
               state_in   = S_MIR_RD;
            end else begin
               cmd.advance = 1'b1;
               state_in    = sts.done_next ? S_SUM : S_EXT;
            end
         end
         S_SUM: begin
            if (sts.slot_free) begin
               cmd.load_sum = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_Q_ODD: begin
            cmd.rad_rd = 1'b1;
            cmd.rd_sel = pre_pkg::RD_ODD;
            state_in   = S_Q_EVEN;
         end
         S_Q_EVEN: begin
            cmd.cap_odd = 1'b1;
            cmd.rad_rd  = 1'b1;
            cmd.rd_sel  = pre_pkg::RD_EVEN;
            state_in    = S_Q_RANGE;
         end
         S_Q_RANGE: begin
            cmd.cap_even = 1'b1;
            cmd.rad_rd   = 1'b1;
            cmd.rd_sel   = pre_pkg::RD_RANGE;
            state_in     = S_Q_RESP;
         end
         S_Q_RESP: begin
            if (sts.slot_free) begin
               cmd.load_qry = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/pre_dpath.sv =====
// ---------------------------------------------------------------------------
// pre_dpath
// Character and radius memories, Manacher registers and response register.
// ---------------------------------------------------------------------------
`include "palindrome_radius_engine_unit_macros.svh"

module pre_dpath #(
   parameter int MAX_LEN = pre_pkg::MAX_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pre_pkg::req_data_type         req_data,
   input  pre_pkg::cmd_type              cmd,
   output pre_pkg::sts_type              sts,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic                          rsp_tuser,
   output logic [pre_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW     = $clog2(MAX_LEN + 1);
   localparam int RDEPTH = 2 * MAX_LEN + 1;
   localparam int NW     = $clog2(RDEPTH);

   // Memories
   logic [pre_pkg::CHAR_W-1:0] char_mem [MAX_LEN];
   logic [NW-1:0]              rad_mem  [RDEPTH];
   logic [pre_pkg::CHAR_W-1:0] ca_ff, cb_ff;
   logic [NW-1:0]              rd_ff;

   // String state
   logic [CW-1:0] count_ff, count_in, cnt_eff;
   logic          built_ff, built_in;
   logic          ovf_ff, ovf_in;
   logic          fits;
   logic [NW-1:0] n_len;

   // Build state
   logic [NW-1:0] c_ff, r_ff, k_ff;
   logic [NW-1:0] best_len_ff;
   logic [AW-1:0] best_start_ff;

   // Query state
   logic [pre_pkg::IDX_W-1:0]   idx_ff;
   logic [pre_pkg::RANGE_W-1:0] rs_ff, re_ff;
   logic [NW-1:0]               ro_ff, rv_ff;

   // Response
   logic                  rsp_valid_ff;
   logic                  rsp_kind_ff;
   pre_pkg::rsp_data_type rsp_data_ff, sum_data, qry_data;

   // Datapath nets
   logic          rad_we;
   logic [NW-1:0] rad_wa, rad_wd, rad_ra, cur_len;
   logic [NW-1:0] lo_pos, cur_start;
   logic [NW:0]   hi_pos, cr_sum, ck_sum, kv_sum;
   logic [11:0]   q_odd, q_even, q_rng, rng_len;
   logic [NW:0]   odd_len_w, even_len_w;
   logic          idx_ok, range_ok, pal;

   // Append bookkeeping
   assign cnt_eff = built_ff ? '0 : count_ff;
   assign fits    = (cnt_eff < CW'(MAX_LEN));
   assign n_len   = NW'({count_ff, 1'b1});

   always_comb begin
      count_in = count_ff;
      built_in = built_ff;
      ovf_in   = ovf_ff;
      if (cmd.append) begin
         built_in = 1'b0;
         if (built_ff) begin
            ovf_in = 1'b0;
         end
         if (fits) begin
            count_in = cnt_eff + CW'(1);
         end else begin
            count_in = cnt_eff;
            ovf_in   = 1'b1;
         end
      end
      if (cmd.load_sum) begin
         built_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         built_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         built_ff <= built_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Character memory: one write, two registered reads
   assign lo_pos = c_ff - r_ff - NW'(1);
   assign hi_pos = {1'b0, c_ff} + {1'b0, r_ff} - (NW+1)'(1);

   always_ff @(posedge clock) begin
      if (cmd.append && fits) begin
         char_mem[cnt_eff[AW-1:0]] <= req_data.char_in;
      end
      if (cmd.char_rd) begin
         ca_ff <= char_mem[AW'(lo_pos >> 1)];
         cb_ff <= char_mem[AW'(hi_pos >> 1)];
      end
   end

   // Radius memory: one write, one registered read
   assign rad_we = cmd.wr_center | cmd.mir_wr;
   assign rad_wa = cmd.wr_center ? c_ff : NW'(ck_sum);
   assign rad_wd = cmd.wr_center ? r_ff : rd_ff;

   assign q_odd  = {1'b0, idx_ff, 1'b1};
   assign q_even = {1'b0, idx_ff, 1'b0} + 12'd2;
   assign q_rng  = {1'b0, rs_ff} + {1'b0, re_ff};

   always_comb begin
      case (cmd.rd_sel)
         pre_pkg::RD_MIRROR: rad_ra = c_ff - k_ff;
         pre_pkg::RD_ODD:    rad_ra = NW'(q_odd);
         pre_pkg::RD_EVEN:   rad_ra = NW'(q_even);
         pre_pkg::RD_RANGE:  rad_ra = NW'(q_rng);
         default:            rad_ra = c_ff - k_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rad_we) begin
         rad_mem[rad_wa] <= rad_wd;
      end
      if (cmd.rad_rd) begin
         rd_ff <= rad_mem[rad_ra];
      end
   end

   // Centre, right reach and mirror offset
   always_ff @(posedge clock) begin
      if (cmd.build_init) begin
         c_ff <= '0;
         r_ff <= '0;
      end else if (cmd.r_inc) begin
         r_ff <= r_ff + NW'(1);
      end else if (cmd.advance) begin
         c_ff <= NW'(ck_sum);
         r_ff <= r_ff - k_ff;
      end
      if (cmd.wr_center) begin
         k_ff <= NW'(1);
      end else if (cmd.mir_wr) begin
         k_ff <= k_ff + NW'(1);
      end
   end

   // Track the first longest palindrome as radii are written in order
   assign cur_len   = rad_wd - NW'(1);
   assign cur_start = (rad_wa + NW'(1) - rad_wd) >> 1;

   always_ff @(posedge clock) begin
      if (reset || cmd.build_init) begin
         best_len_ff   <= '0;
         best_start_ff <= '0;
      end else if (rad_we && (cur_len > best_len_ff)) begin
         best_len_ff   <= cur_len;
         best_start_ff <= AW'(cur_start);
      end
   end

   // Status
   assign cr_sum = {1'b0, c_ff} + {1'b0, r_ff};
   assign ck_sum = {1'b0, c_ff} + {1'b0, k_ff};
   assign kv_sum = {1'b0, k_ff} + {1'b0, rd_ff};

   assign sts.slot_free = !rsp_valid_ff || rsp_tready;
   assign sts.bounds_ok = (c_ff >= r_ff) && (cr_sum < {1'b0, n_len});
   assign sts.sep_pos   = !(c_ff[0] ^ r_ff[0]);
   assign sts.chars_eq  = (ca_ff == cb_ff);
   assign sts.mir_ok    = (k_ff <= c_ff);
   assign sts.mir_more  = (kv_sum < {1'b0, r_ff});
   assign sts.done_next = (ck_sum >= {1'b0, n_len});

   // Query operands and captured radii
   always_ff @(posedge clock) begin
      if (cmd.latch_q) begin
         idx_ff <= req_data.index;
         rs_ff  <= req_data.range_start;
         re_ff  <= req_data.range_end;
      end
      if (cmd.cap_odd) begin
         ro_ff <= rd_ff >> 1;
      end
      if (cmd.cap_even) begin
         rv_ff <= rd_ff >> 1;
      end
   end

   // Build answers
   assign odd_len_w  = (ro_ff == '0) ? '0 : ({ro_ff, 1'b0} - (NW+1)'(1));
   assign even_len_w = {rv_ff, 1'b0};
   assign idx_ok     = (idx_ff < count_ff);
   assign range_ok   = (rs_ff <= re_ff) && (re_ff <= count_ff);
   assign rng_len    = {1'b0, re_ff} - {1'b0, rs_ff} + 12'd1;
   assign pal        = ((rd_ff >> 1) >= (rng_len >> 1));

   always_comb begin
      sum_data               = '0;
      sum_data.longest_len   = pre_pkg::LEN_W'(best_len_ff);
      sum_data.longest_start = pre_pkg::START_W'(best_start_ff);
      sum_data.error         = ovf_ff;
   end

   always_comb begin
      qry_data = '0;
      if (!built_ff) begin
         qry_data.error = 1'b1;
      end else begin
         qry_data.longest_len   = pre_pkg::LEN_W'(best_len_ff);
         qry_data.longest_start = pre_pkg::START_W'(best_start_ff);
         if (idx_ok) begin
            qry_data.odd_radius  = pre_pkg::RAD_W'(ro_ff);
            qry_data.odd_len     = pre_pkg::OLEN_W'(odd_len_w);
            qry_data.even_radius = pre_pkg::RAD_W'(rv_ff);
            qry_data.even_len    = pre_pkg::ELEN_W'(even_len_w);
         end
         qry_data.is_pal = range_ok && pal;
         qry_data.error  = !idx_ok || !range_ok;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_sum || cmd.load_qry) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sum) begin
         rsp_kind_ff <= pre_pkg::KIND_SUMMARY;
         rsp_data_ff <= sum_data;
      end else if (cmd.load_qry) begin
         rsp_kind_ff <= pre_pkg::KIND_QUERY;
         rsp_data_ff <= qry_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `PRE_ASSERT_IMP(a_rad_wr_in_string, rad_we, rad_wa < n_len, "radius write beyond string")
   `PRE_ASSERT_IMP(a_load_slot_free, cmd.load_sum || cmd.load_qry, !rsp_valid_ff || rsp_tready, "response overwritten")
   `PRE_ASSERT_NXT(a_rsp_drains, rsp_valid_ff && rsp_tready && !cmd.load_sum && !cmd.load_qry, !rsp_valid_ff, "taken beat repeated")
   `PRE_ASSERT_IMP(a_one_writer, cmd.wr_center, !cmd.mir_wr, "two radius writes at once")

endmodule

// ===== src/palindrome_radius_engine_unit.sv =====
// ---------------------------------------------------------------------------
// palindrome_radius_engine_unit
// Manacher longest-palindrome engine with per-index radius queries and range palindrome checks.
// ---------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                               | tuser   | tlast
//  req_    | in  | char_in, index, range_start, range_end           | action  | last
//  rsp_    | out | longest_len, longest_start, odd_radius, odd_len, | kind    | -
//          |     | even_radius, even_len, is_pal, error             |         |
//
// An append is accepted from the idle state. A query issues three
// sequential reads of the radius memory's single read port.
// A build runs separator steps, character compares, mirrored centres
// and new centres over the stored chars.
// Reset is synchronous and clears counts and flags; memories are not cleared.
// A result waits in the output register while the next item is accepted.
// ---------------------------------------------------------------------------
module palindrome_radius_engine_unit #(
   parameter int MAX_LEN = pre_pkg::MAX_LEN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // char_in[7:0], index[17:8], range_start[28:18], range_end[39:29]
   input  logic [pre_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[0]
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // longest_len[10:0], longest_start[20:11], odd_radius[30:21],
   // odd_len[40:31], even_radius[50:41], even_len[61:51], is_pal[62], error[63]
   output logic [pre_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // kind[0]
   output logic                           rsp_tuser
);

   pre_pkg::cmd_type      cmd;
   pre_pkg::sts_type      sts;
   pre_pkg::req_data_type req_data;

   assign req_data = req_tdata;

   // Sequencer
   pre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_last   (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Storage and arithmetic
   pre_dpath #(
      .MAX_LEN (MAX_LEN)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
